[sv/assert_macros.svh]
// Assertion macros used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/nll_pkg.sv]
// Shared types and constants of the nonlinear ladder lowpass.
package nll_pkg;

  localparam int SampleW = 24;
  localparam int CfgW    = 24;
  localparam int CfgIdxW = 2;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic [CfgIdxW-1:0]        cfg_idx_t;

  localparam cfg_idx_t CfgStageGain = 2'd0;
  localparam cfg_idx_t CfgInvTwoVt  = 2'd1;
  localparam cfg_idx_t CfgResonance = 2'd2;

  localparam logic [23:0] InvTwoVtReset = 24'd1260307;

endpackage

[sv/nll_in_if.sv]
// Request channel carrying one filter or flush request.
interface nll_in_if import nll_pkg::*; ();
  logic    valid;
  logic    ready;
  logic    op;
  sample_t sample_in;
  logic    block_end_in;

  modport source(output valid, output op, output sample_in, output block_end_in,
                 input ready);
  modport sink(input valid, input op, input sample_in, input block_end_in,
               output ready);
endinterface

[sv/nll_out_if.sv]
// Result channel carrying one filtered sample.
interface nll_out_if import nll_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample_out;
  logic    block_end_out;

  modport source(output valid, output sample_out, output block_end_out, input ready);
  modport sink(input valid, input sample_out, input block_end_out, output ready);
endinterface

[sv/nonlinear_ladder_lowpass.sv]
// Four-pole nonlinear ladder lowpass built around one shared multiplier.
//
//   channel  | direction | contents
//   in_ch    | sink      | op, sample_in, block_end_in
//   out_ch   | source    | sample_out, block_end_out
//   cfg_*    | write     | stage_gain, inv_two_vt, resonance
//
// A filter request runs through the feedback, tanh lookup and stage update states,
// which take turns on the shared multiplier and the single table read port;
// in_ch.ready rises in the same cycle as out_ch.valid, so a new request is taken
// only once the last one is through. A flush request clears the stage state and
// goes straight to the output state. After reset the tanh table is computed with
// a shift-subtract divider while in_ch.ready stays low.
// A stalled result holds the block in its output state until out_ch.ready rises.
`include "assert_macros.svh"

module nonlinear_ladder_lowpass import nll_pkg::*; #(
  parameter int STAGE_COUNT      = 4,
  parameter int TANH_TABLE_DEPTH = 1024
) (
  input  logic            clk,
  input  logic            rst_n,
  nll_in_if.sink          in_ch,
  nll_out_if.source       out_ch,
  input  logic            cfg_we,
  input  cfg_idx_t        cfg_index,
  input  logic [CfgW-1:0] cfg_wdata
);

  localparam int IdxW = $clog2(TANH_TABLE_DEPTH + 1);
  localparam int StgW = (STAGE_COUNT > 1) ? $clog2(STAGE_COUNT) : 1;
  localparam logic [IdxW-1:0] LastAddr  = IdxW'(TANH_TABLE_DEPTH);
  localparam logic [StgW-1:0] LastStage = StgW'(STAGE_COUNT - 1);
  localparam logic [4:0]      LastDivStep = 5'd23;

  // Series for exp(-16/TANH_TABLE_DEPTH) in Q.32, the per-entry step of exp(-2x).
  localparam longint OneQ32    = 64'sd1 <<< 32;
  localparam longint ExpTerm1  = (OneQ32 * 16) / (TANH_TABLE_DEPTH * 1);
  localparam longint ExpTerm2  = (ExpTerm1 * 16) / (TANH_TABLE_DEPTH * 2);
  localparam longint ExpTerm3  = (ExpTerm2 * 16) / (TANH_TABLE_DEPTH * 3);
  localparam longint ExpTerm4  = (ExpTerm3 * 16) / (TANH_TABLE_DEPTH * 4);
  localparam longint ExpTerm5  = (ExpTerm4 * 16) / (TANH_TABLE_DEPTH * 5);
  localparam longint ExpTerm6  = (ExpTerm5 * 16) / (TANH_TABLE_DEPTH * 6);
  localparam longint ExpTerm7  = (ExpTerm6 * 16) / (TANH_TABLE_DEPTH * 7);
  localparam longint ExpTerm8  = (ExpTerm7 * 16) / (TANH_TABLE_DEPTH * 8);
  localparam longint ExpTerm9  = (ExpTerm8 * 16) / (TANH_TABLE_DEPTH * 9);
  localparam longint ExpTerm10 = (ExpTerm9 * 16) / (TANH_TABLE_DEPTH * 10);
  localparam longint ExpTerm11 = (ExpTerm10 * 16) / (TANH_TABLE_DEPTH * 11);
  localparam longint ExpTerm12 = (ExpTerm11 * 16) / (TANH_TABLE_DEPTH * 12);
  localparam longint ExpTerm13 = (ExpTerm12 * 16) / (TANH_TABLE_DEPTH * 13);
  localparam longint ExpTerm14 = (ExpTerm13 * 16) / (TANH_TABLE_DEPTH * 14);
  localparam longint ExpTerm15 = (ExpTerm14 * 16) / (TANH_TABLE_DEPTH * 15);
  localparam longint ExpTerm16 = (ExpTerm15 * 16) / (TANH_TABLE_DEPTH * 16);
  localparam longint ExpSeries = OneQ32 - ExpTerm1 + ExpTerm2 - ExpTerm3 + ExpTerm4
                                 - ExpTerm5 + ExpTerm6 - ExpTerm7 + ExpTerm8
                                 - ExpTerm9 + ExpTerm10 - ExpTerm11 + ExpTerm12
                                 - ExpTerm13 + ExpTerm14 - ExpTerm15 + ExpTerm16;

  localparam logic [31:0] ExpStep = 32'(ExpSeries);

  localparam logic [4:0] ST_B_DIV   = 5'd0;
  localparam logic [4:0] ST_B_MLO   = 5'd1;
  localparam logic [4:0] ST_B_MHI   = 5'd2;
  localparam logic [4:0] ST_B_UPD   = 5'd3;
  localparam logic [4:0] ST_IDLE    = 5'd4;
  localparam logic [4:0] ST_FB_MUL  = 5'd5;
  localparam logic [4:0] ST_FB      = 5'd6;
  localparam logic [4:0] ST_T_ARG   = 5'd7;
  localparam logic [4:0] ST_T_IDX   = 5'd8;
  localparam logic [4:0] ST_T_MUL   = 5'd9;
  localparam logic [4:0] ST_T_ADDR  = 5'd10;
  localparam logic [4:0] ST_T_RDLO  = 5'd11;
  localparam logic [4:0] ST_T_RDHI  = 5'd12;
  localparam logic [4:0] ST_T_DONE  = 5'd13;
  localparam logic [4:0] ST_GAIN    = 5'd14;
  localparam logic [4:0] ST_LEVEL   = 5'd15;
  localparam logic [4:0] ST_OUT     = 5'd16;

  logic [4:0] state_r;

  logic [23:0] gain_r;
  logic [23:0] inv_r;
  logic [17:0] res_r;

  logic signed [31:0] level_r [STAGE_COUNT];
  logic signed [25:0] tnh_r   [STAGE_COUNT];

  sample_t            x_r;
  logic               bend_r;
  logic signed [25:0] drive_r;
  logic signed [31:0] y_r;
  logic signed [36:0] v_r;
  logic [26:0]        m_r;
  logic               neg_r;
  logic               sat_r;
  logic [IdxW-1:0]    idx_r;
  logic [26:0]        frac_r;
  logic signed [24:0] lo_r;
  logic               ret_r;
  logic [StgW-1:0]    stg_r;
  logic signed [61:0] prod_r;

  logic [IdxW-1:0] bidx_r;
  logic [4:0]      dcnt_r;
  logic [32:0]     t_r;
  logic [33:0]     rem_r;
  logic [22:0]     quo_r;
  logic [49:0]     acc_r;

  logic [23:0] tbl_mem [TANH_TABLE_DEPTH+1];
  logic [23:0] rd_r;

  logic    out_valid_r;
  sample_t out_sample_r;
  logic    out_bend_r;

  logic signed [36:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [61:0] mul_p;
  logic [IdxW-1:0]    rd_addr;
  logic               in_fire;
  logic               out_free;

  logic signed [26:0] diff_w;
  logic signed [24:0] hi_w;
  logic [45:0]        arg_w;
  logic [45:0]        mag_w;
  logic [IdxW-1:0]    idx_w;
  logic signed [25:0] tres_w;
  logic signed [25:0] tmag_w;
  logic signed [33:0] ysum_w;
  logic signed [31:0] ysat_w;
  logic [34:0]        den_w;
  logic [34:0]        r2_w;
  logic               qbit_w;
  logic [65:0]        full_w;
  logic [32:0]        tnew_w;
  logic signed [30:0] yhalf_w;
  sample_t            osat_w;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  assign in_ch.ready          = (state_r == ST_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.sample_out    = out_sample_r;
  assign out_ch.block_end_out = out_bend_r;

  assign diff_w = 27'(drive_r) - 27'(tnh_r[0]);
  assign hi_w   = $signed({1'b0, rd_r});

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_FB_MUL: begin
        mul_a = 37'(level_r[STAGE_COUNT-1]);
        mul_b = 25'($signed({1'b0, res_r}));
      end
      ST_T_ARG: begin
        mul_a = v_r;
        mul_b = $signed({1'b0, inv_r});
      end
      ST_T_MUL: begin
        mul_a = 37'($signed({1'b0, m_r}));
        mul_b = 25'(TANH_TABLE_DEPTH);
      end
      ST_T_RDHI: begin
        mul_a = 37'($signed({1'b0, frac_r}));
        mul_b = hi_w - lo_r;
      end
      ST_GAIN: begin
        mul_a = 37'(diff_w);
        mul_b = $signed({1'b0, gain_r});
      end
      ST_B_MLO: begin
        mul_a = $signed({4'b0, t_r});
        mul_b = $signed({9'b0, ExpStep[15:0]});
      end
      ST_B_MHI: begin
        mul_a = $signed({4'b0, t_r});
        mul_b = $signed({9'b0, ExpStep[31:16]});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // tanh argument handling: magnitude, and saturation at 8.0 in Q.24.
  assign arg_w = prod_r[61:16];
  assign mag_w = arg_w[45] ? (~arg_w + 46'd1) : arg_w;
  assign idx_w = sat_r ? LastAddr : prod_r[27+IdxW-1:27];

  always_comb begin
    rd_addr = idx_w;
    if (state_r == ST_T_RDLO) begin
      rd_addr = sat_r ? idx_r : idx_r + IdxW'(1);
    end
  end

  assign tmag_w = 26'(lo_r) + 26'(prod_r >>> 27);
  assign tres_w = neg_r ? -tmag_w : tmag_w;

  assign ysum_w = 34'(level_r[0]) + 34'(prod_r >>> 24);
  always_comb begin
    if (ysum_w > 34'sd2147483647) ysat_w = 32'sh7fffffff;
    else if (ysum_w < -34'sd2147483648) ysat_w = 32'sh80000000;
    else ysat_w = ysum_w[31:0];
  end

  // One restoring division step of ((1-t) << 24) / (1+t).
  assign den_w  = 35'h1_0000_0000 + 35'(t_r);
  assign r2_w   = {rem_r, 1'b0};
  assign qbit_w = (r2_w >= den_w);

  assign full_w = 66'(acc_r) + (66'(prod_r[49:0]) << 16) + 66'h8000_0000;
  assign tnew_w = full_w[64:32];

  assign yhalf_w = y_r[31:1];
  always_comb begin
    if (yhalf_w > 31'sd8388607) osat_w = 24'sh7fffff;
    else if (yhalf_w < -31'sd8388608) osat_w = 24'sh800000;
    else osat_w = yhalf_w[23:0];
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_B_DIV && dcnt_r == LastDivStep) begin
      tbl_mem[bidx_r] <= {quo_r, qbit_w};
    end
  end

  always_ff @(posedge clk) begin
    rd_r <= tbl_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_p;
    if (!rst_n) begin
      state_r     <= ST_B_DIV;
      gain_r      <= '0;
      inv_r       <= InvTwoVtReset;
      res_r       <= '0;
      out_valid_r <= 1'b0;
      bidx_r      <= '0;
      dcnt_r      <= '0;
      t_r         <= 33'h1_0000_0000;
      rem_r       <= '0;
      stg_r       <= '0;
      for (int i = 0; i < STAGE_COUNT; i++) begin
        level_r[i] <= '0;
        tnh_r[i]   <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CfgStageGain: gain_r <= cfg_wdata[23:0];
          CfgInvTwoVt:  inv_r  <= cfg_wdata[23:0];
          CfgResonance: res_r  <= cfg_wdata[17:0];
          default: ;
        endcase
      end

      if (state_r == ST_OUT && out_free) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;

      unique case (state_r)
        ST_B_DIV: begin
          rem_r  <= qbit_w ? 34'(r2_w - den_w) : 34'(r2_w);
          quo_r  <= {quo_r[21:0], qbit_w};
          dcnt_r <= dcnt_r + 5'd1;
          if (dcnt_r == LastDivStep) state_r <= ST_B_MLO;
        end
        ST_B_MLO: state_r <= ST_B_MHI;
        ST_B_MHI: begin
          acc_r   <= prod_r[49:0];
          state_r <= ST_B_UPD;
        end
        ST_B_UPD: begin
          t_r    <= tnew_w;
          rem_r  <= 34'h1_0000_0000 - 34'(tnew_w);
          dcnt_r <= '0;
          if (bidx_r == LastAddr) begin
            state_r <= ST_IDLE;
          end else begin
            bidx_r  <= bidx_r + IdxW'(1);
            state_r <= ST_B_DIV;
          end
        end
        ST_IDLE: begin
          if (in_fire) begin
            x_r    <= in_ch.sample_in;
            bend_r <= in_ch.block_end_in;
            if (in_ch.op) begin
              for (int i = 0; i < STAGE_COUNT; i++) begin
                level_r[i] <= '0;
                tnh_r[i]   <= '0;
              end
              y_r     <= '0;
              state_r <= ST_OUT;
            end else begin
              state_r <= ST_FB_MUL;
            end
          end
        end
        ST_FB_MUL: state_r <= ST_FB;
        ST_FB: begin
          // Feedback 4*r*y >> 16 equals r*y >> 14.
          v_r     <= (37'(x_r) <<< 1) - 37'(prod_r >>> 14);
          ret_r   <= 1'b0;
          state_r <= ST_T_ARG;
        end
        ST_T_ARG: state_r <= ST_T_IDX;
        ST_T_IDX: begin
          m_r     <= mag_w[26:0];
          neg_r   <= arg_w[45];
          sat_r   <= |mag_w[45:27];
          state_r <= ST_T_MUL;
        end
        ST_T_MUL: state_r <= ST_T_ADDR;
        ST_T_ADDR: begin
          idx_r   <= idx_w;
          frac_r  <= sat_r ? '0 : prod_r[26:0];
          state_r <= ST_T_RDLO;
        end
        ST_T_RDLO: begin
          lo_r    <= $signed({1'b0, rd_r});
          state_r <= ST_T_RDHI;
        end
        ST_T_RDHI: state_r <= ST_T_DONE;
        ST_T_DONE: begin
          drive_r <= tres_w;
          if (!ret_r) begin
            stg_r   <= '0;
            state_r <= ST_GAIN;
          end else begin
            // Rotate the stage ring so that the next stage sits at entry zero.
            for (int i = 0; i < STAGE_COUNT - 1; i++) begin
              level_r[i] <= level_r[i+1];
              tnh_r[i]   <= tnh_r[i+1];
            end
            level_r[STAGE_COUNT-1] <= y_r;
            tnh_r[STAGE_COUNT-1]   <= tres_w;
            if (stg_r == LastStage) begin
              state_r <= ST_OUT;
            end else begin
              stg_r   <= stg_r + StgW'(1);
              state_r <= ST_GAIN;
            end
          end
        end
        ST_GAIN: state_r <= ST_LEVEL;
        ST_LEVEL: begin
          y_r     <= ysat_w;
          v_r     <= 37'(ysat_w);
          ret_r   <= 1'b1;
          state_r <= ST_T_ARG;
        end
        ST_OUT: begin
          if (out_free) begin
            out_sample_r <= osat_w;
            out_bend_r   <= bend_r;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  `ASSERT_NEXT(a_flush_zero, in_fire && in_ch.op,
               state_r == ST_OUT && y_r == '0, "flush did not clear the output level")
  `ASSERT_IMPLIES(a_build_quiet,
                  state_r == ST_B_DIV || state_r == ST_B_MLO ||
                  state_r == ST_B_MHI || state_r == ST_B_UPD,
                  !out_valid_r && !in_ch.ready, "traffic during table build")
  `ASSERT_IMPLIES(a_sat_lookup, state_r == ST_T_RDLO && sat_r,
                  frac_r == '0 && idx_r == LastAddr,
                  "saturated tanh lookup not pinned to the last entry")
  `ASSERT_NEXT(a_out_hold, state_r == ST_OUT && out_valid_r && !out_ch.ready,
               state_r == ST_OUT, "result overwritten while stalled")

endmodule

[sim/tb_nonlinear_ladder_lowpass.sv]
// Self-checking testbench for the four-pole nonlinear ladder lowpass.
module tb_nonlinear_ladder_lowpass;
  import nll_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int       Stages     = 4;
  localparam int       Depth      = 1024;
  localparam longint   ArgLimit   = 64'sd1 << 27;
  localparam int       CycleLimit = 3000000;
  localparam cfg_idx_t CfgUnused  = 2'd3;

  typedef enum logic {OpFilter = 1'b0, OpFlush = 1'b1} filter_op_e;

  typedef struct {
    filter_op_e op;
    sample_t    sample;
    logic       block_end;
  } audio_req_t;

  typedef struct {
    sample_t sample;
    logic    block_end;
  } audio_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  cfg_idx_t cfg_index = CfgStageGain;
  logic [CfgW-1:0] cfg_wdata = '0;

  nll_in_if  in_ch();
  nll_out_if out_ch();

  nonlinear_ladder_lowpass dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mirror of the filter state and registers.
  longint tanh_tab [0:Depth];
  longint level [Stages];
  longint squash [Stages];
  longint gain_q24;
  longint inv_vt_q16;
  longint reso_q16;

  audio_req_t pending_reqs[$];
  audio_res_t expected_samples[$];
  int  mismatches = 0;
  int  sent_count = 0;
  int  flush_count = 0;
  int  result_count = 0;
  int  cycles = 0;
  bit  calm = 1'b0;

  function automatic void build_tanh_table();
    longint q, term;
    longint unsigned t, num, den;
    q = 64'sd1 << 32;
    term = 64'sd1 << 32;
    t = 64'd1 << 32;
    for (int k = 1; k <= 16; k++) begin
      term = (term * 16) / (longint'(Depth) * k);
      if (k % 2 == 1) q -= term;
      else q += term;
    end
    for (int i = 0; i <= Depth; i++) begin
      num = ((64'd1 << 32) - t) << 24;
      den = (64'd1 << 32) + t;
      tanh_tab[i] = longint'(num / den);
      t = (t * longint'(unsigned'(q)) + (64'd1 << 31)) >> 32;
    end
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint tanh_lookup(longint a);
    longint m, r, p, idx, frac;
    m = a < 0 ? -a : a;
    if (m >= ArgLimit) begin
      r = tanh_tab[Depth];
    end else begin
      p = m * Depth;
      idx = p >>> 27;
      frac = p & (ArgLimit - 1);
      if (idx > Depth - 1) idx = Depth - 1;
      r = tanh_tab[idx] + (((tanh_tab[idx+1] - tanh_tab[idx]) * frac) >>> 27);
    end
    return a < 0 ? -r : r;
  endfunction

  function automatic longint squash_scaled(longint v);
    return tanh_lookup(clamp((v * inv_vt_q16) >>> 16, -2 * ArgLimit, 2 * ArgLimit));
  endfunction

  function automatic audio_res_t ladder_step(audio_req_t req);
    audio_res_t res;
    longint drive, y, fb;
    res.block_end = req.block_end;
    if (req.op == OpFlush) begin
      foreach (level[k]) begin
        level[k] = 0;
        squash[k] = 0;
      end
      res.sample = '0;
      return res;
    end
    for (int k = 0; k < Stages; k++) begin
      if (k == 0) begin
        fb = (4 * reso_q16 * level[Stages-1]) >>> 16;
        drive = squash_scaled(longint'(req.sample) * 2 - fb);
      end else begin
        drive = squash[k-1];
      end
      y = level[k] + ((gain_q24 * (drive - squash[k])) >>> 24);
      level[k] = clamp(y, -(64'sd1 << 31), (64'sd1 << 31) - 1);
      squash[k] = squash_scaled(level[k]);
    end
    res.sample = sample_t'(clamp(level[Stages-1] >>> 1, -8388608, 8388607));
    return res;
  endfunction

  // Driver: offers pending requests with random idle bursts.
  int send_gap = 0;
  always @(posedge clk) begin
    audio_req_t acc, nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.op <= 1'b0;
      in_ch.sample_in <= '0;
      in_ch.block_end_in <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        acc.op = filter_op_e'(in_ch.op);
        acc.sample = in_ch.sample_in;
        acc.block_end = in_ch.block_end_in;
        expected_samples.push_back(ladder_step(acc));
        sent_count++;
        if (acc.op == OpFlush) flush_count++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_ch.valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          nxt = pending_reqs.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.op <= nxt.op;
          in_ch.sample_in <= nxt.sample;
          in_ch.block_end_in <= nxt.block_end;
          if (!calm && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 4);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random stalls, one long hold-off, and the result check.
  int  stall_left = 0;
  bit  long_hold_done = 1'b0;
  always @(posedge clk) begin
    audio_res_t exp_res;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        result_count++;
        if (expected_samples.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %0d", out_ch.sample_out);
        end else begin
          exp_res = expected_samples.pop_front();
          if (out_ch.sample_out !== exp_res.sample ||
              out_ch.block_end_out !== exp_res.block_end) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch at result %0d: sample exp %0d got %0d, end exp %b got %b",
                       result_count, exp_res.sample, out_ch.sample_out,
                       exp_res.block_end, out_ch.block_end_out);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ch.ready <= 1'b0;
      end else if (!long_hold_done && result_count >= 300) begin
        // Hold off long enough for the block to back up its input.
        long_hold_done <= 1'b1;
        stall_left <= 600;
        out_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left <= $urandom_range(0, 3);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("nonlinear_ladder_lowpass verification failed");
      $finish;
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [CfgW-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      CfgStageGain: gain_q24 = longint'(value);
      CfgInvTwoVt:  inv_vt_q16 = longint'(value);
      CfgResonance: reso_q16 = longint'(value[17:0]);
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_filter(logic [CfgW-1:0] g, logic [CfgW-1:0] ivt, logic [CfgW-1:0] r);
    write_reg(CfgStageGain, g);
    write_reg(CfgInvTwoVt, ivt);
    write_reg(CfgResonance, r);
  endtask

  task automatic queue_req(filter_op_e op, int s, logic be);
    audio_req_t r;
    r.op = op;
    r.sample = sample_t'(s);
    r.block_end = be;
    pending_reqs.push_back(r);
  endtask

  task automatic drain();
    wait (pending_reqs.size() == 0 && !in_ch.valid && expected_samples.size() == 0);
    repeat (70) @(posedge clk);
  endtask

  task automatic queue_random(int n);
    int pick, s;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) s = int'($urandom);
      else if (pick < 85) s = $urandom_range(0, 8191) - 4096;
      else s = ($urandom_range(0, 1) == 1) ? 8388607 : -8388608;
      queue_req(($urandom_range(0, 39) == 0) ? OpFlush : OpFilter, s,
                $urandom_range(0, 7) == 0);
    end
  endtask

  initial begin
    build_tanh_table();
    foreach (level[k]) begin
      level[k] = 0;
      squash[k] = 0;
    end
    gain_q24 = 0;
    inv_vt_q16 = longint'(InvTwoVtReset);
    reso_q16 = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Reset registers: zero gain means the state never moves.
    queue_req(OpFilter, 8388607, 1'b0);
    queue_req(OpFilter, -8388608, 1'b1);
    drain();

    // Strong drive with full resonance; high bits above resonance are dropped,
    // and a write to the unused index must change nothing.
    set_filter(24'h400000, InvTwoVtReset, 24'hFC0000 | 24'h3FFFF);
    write_reg(CfgUnused, 24'hFFFFFF);
    queue_req(OpFilter, 8388607, 1'b0);
    queue_req(OpFilter, 8388607, 1'b0);
    queue_req(OpFilter, -8388608, 1'b1);
    queue_req(OpFilter, 0, 1'b0);
    queue_req(OpFlush, 12345, 1'b1);
    queue_req(OpFlush, -1, 1'b0);
    queue_req(OpFilter, 1, 1'b0);
    queue_req(OpFilter, -1, 1'b1);
    drain();

    // Register maxima saturate both the stage levels and the output.
    set_filter(24'hFFFFFF, 24'hFFFFFF, 24'h03FFFF);
    for (int i = 0; i < 8; i++) queue_req(OpFilter, (i % 2 == 1) ? -8388608 : 8388607, i == 7);
    queue_req(OpFlush, 0, 1'b0);
    drain();

    // Zero inverse thermal voltage gives zero tanh arguments.
    set_filter(24'h800000, 24'h000000, 24'h010000);
    for (int i = 0; i < 5; i++) queue_req(OpFilter, 8388607 - i, 1'b0);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      set_filter(CfgW'($urandom_range(0, 3) == 0 ? $urandom_range(0, 24'hFFFFFF)
                                                 : $urandom_range(24'h010000, 24'h600000)),
                 CfgW'($urandom_range(0, 3) == 0 ? $urandom_range(0, 24'hFFFFFF)
                                                 : $urandom_range(24'h040000, 24'h200000)),
                 CfgW'($urandom_range(0, 24'h3FFFF)));
      if (ph == 7) calm = 1'b1;
      queue_random(200);
      drain();
    end

    $display("run covered %0d requests (%0d flushes) over %0d register settings,",
             sent_count, flush_count, 12);
    $display("with random stalls on both channels and one long output hold-off");
    if (mismatches == 0 && expected_samples.size() == 0) begin
      $display("nonlinear_ladder_lowpass verification clean");
    end else begin
      $display("nonlinear_ladder_lowpass verification failed");
    end
    $finish;
  end

endmodule
